FILE: sv/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg: alarm tone sequencer shared definitions
// Level codes, register indexes, reset values and channel word types.
// ----------------------------------------------------------------------------
package ats_pkg;

	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned COUNT_W  = 17;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [1:0]            level_t;
	typedef logic [PERIOD_W-1:0]   period_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [PHASE_W-1:0]    phase_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam level_t LEVEL_NONE   = 2'd0;
	localparam level_t LEVEL_LOW    = 2'd1;
	localparam level_t LEVEL_MEDIUM = 2'd2;
	localparam level_t LEVEL_HIGH   = 2'd3;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_FLAGS = 1'b1;

	localparam int unsigned FLAG_HIGH   = 3;
	localparam int unsigned FLAG_MEDIUM = 2;
	localparam int unsigned FLAG_LOW    = 1;
	localparam int unsigned FLAG_NONE   = 0;

	localparam cfg_idx_t REG_TONE_HIGH   = 3'd0;
	localparam cfg_idx_t REG_TONE_MEDIUM = 3'd1;
	localparam cfg_idx_t REG_TONE_LOW    = 3'd2;
	localparam cfg_idx_t REG_CHOP_TICKS  = 3'd3;
	localparam cfg_idx_t REG_SECOND_TICKS = 3'd4;

	localparam period_t RST_TONE_HIGH    = 16'd450;
	localparam period_t RST_TONE_MEDIUM  = 16'd700;
	localparam period_t RST_TONE_LOW     = 16'd950;
	localparam period_t RST_CHOP_TICKS   = 16'd125;
	localparam period_t RST_SECOND_TICKS = 16'd1000;
	localparam period_t RST_PERIOD_HOLD  = 16'd400;

	localparam phase_t PHASE_TONE2 = 3'd4;

	typedef struct packed {
		logic       cmd;
		logic [3:0] alert_bits;
	} event_word_t;

	typedef struct packed {
		period_t pwm_period;
		logic    speaker_on;
		level_t  alarm_level;
	} tone_word_t;

endpackage

FILE: sv/ats_if.sv
// ----------------------------------------------------------------------------
// ats_if: valid/ready channels of the alarm tone sequencer
// Event channel (tick or flags) and tone channel (period, enable, level).
// ----------------------------------------------------------------------------
interface ats_event_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [3:0] alert_bits;

	modport source (output valid, output cmd, output alert_bits, input ready);
	modport sink (input valid, input cmd, input alert_bits, output ready);
endinterface

interface ats_tone_if;
	logic        valid;
	logic        ready;
	logic [15:0] pwm_period;
	logic        speaker_on;
	logic [1:0]  alarm_level;

	modport source (output valid, output pwm_period, output speaker_on,
		output alarm_level, input ready);
	modport sink (input valid, input pwm_period, input speaker_on,
		input alarm_level, output ready);
endinterface

FILE: sv/alarm_tone_sequencer_top.sv
// ----------------------------------------------------------------------------
// alarm_tone_sequencer_top: alarm buzzer pattern sequencer
// Steps the low, medium and chopped high alarm patterns on ticks and
// flag events and reports PWM period, speaker enable and level per word.
// ----------------------------------------------------------------------------
//  channel   dir  word                                    handshake
//  events    in   cmd, alert_bits                         valid/ready
//  tones     out  pwm_period, speaker_on, alarm_level     valid/ready
//  cfg       in   cfg_index, cfg_data                     cfg_we, no wait
//
//  One word is taken per cycle while tones is not stalled; its tone word
//  is registered and shows the cycle after acceptance. The next event
//  word is taken in the same cycle the held tone word is taken. A stall
//  on tones holds the tone word and blocks events only while it is
//  unread. Reset loads the register defaults and clears the pattern;
//  there is no clearing pass.
module alarm_tone_sequencer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  ats_pkg::cfg_idx_t  cfg_index,
	input  ats_pkg::cfg_data_t cfg_data,
	ats_event_if.sink         events,
	ats_tone_if.source        tones
);
	import ats_pkg::*;

	period_t tone_high_q, tone_medium_q, tone_low_q, chop_ticks_q, second_ticks_q;

	level_t  level_q, level_d;
	phase_t  phase_q, phase_d;
	count_t  count_q, count_d;
	period_t period_q, period_d;
	logic    spk_q, spk_d;

	logic       out_valid_q;
	tone_word_t out_word_q;
	logic       accept;

	count_t  count_inc;
	count_t  phase_len;
	phase_t  phase_next;
	period_t tone1, tone2;

	assign events.ready = !out_valid_q || tones.ready;
	assign accept = events.valid && events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_high_q    <= RST_TONE_HIGH;
			tone_medium_q  <= RST_TONE_MEDIUM;
			tone_low_q     <= RST_TONE_LOW;
			chop_ticks_q   <= RST_CHOP_TICKS;
			second_ticks_q <= RST_SECOND_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TONE_HIGH:    tone_high_q    <= cfg_data;
				REG_TONE_MEDIUM:  tone_medium_q  <= cfg_data;
				REG_TONE_LOW:     tone_low_q     <= cfg_data;
				REG_CHOP_TICKS:   chop_ticks_q   <= cfg_data;
				REG_SECOND_TICKS: second_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (level_q)
			LEVEL_HIGH: phase_len = {1'b0, chop_ticks_q};
			LEVEL_LOW:  phase_len = {second_ticks_q, 1'b0};
			default:    phase_len = {1'b0, second_ticks_q};
		endcase
		// tone pairs: low = low/medium, medium = medium/high, high = low/high
		tone1 = (level_q == LEVEL_MEDIUM) ? tone_medium_q : tone_low_q;
		tone2 = (level_q == LEVEL_LOW) ? tone_medium_q : tone_high_q;
		count_inc = count_q + 1'b1;
		if (level_q == LEVEL_HIGH) begin
			phase_next = phase_q + 1'b1;
		end else begin
			phase_next = (phase_q == '0) ? 3'd1 : 3'd0;
		end
	end

	always_comb begin
		level_d  = level_q;
		phase_d  = phase_q;
		count_d  = count_q;
		period_d = period_q;
		spk_d    = spk_q;
		if (events.cmd == CMD_FLAGS) begin
			priority if (events.alert_bits[FLAG_HIGH] && level_q != LEVEL_HIGH) begin
				level_d  = LEVEL_HIGH;
				phase_d  = '0;
				count_d  = '0;
				period_d = tone_low_q;
				spk_d    = 1'b1;
			end else if (events.alert_bits[FLAG_MEDIUM] && level_q != LEVEL_MEDIUM) begin
				level_d  = LEVEL_MEDIUM;
				phase_d  = '0;
				count_d  = '0;
				period_d = tone_medium_q;
				spk_d    = 1'b1;
			end else if (events.alert_bits[FLAG_LOW] && level_q != LEVEL_LOW) begin
				level_d  = LEVEL_LOW;
				phase_d  = '0;
				count_d  = '0;
				period_d = tone_low_q;
				spk_d    = 1'b1;
			end else if (events.alert_bits[FLAG_NONE]) begin
				// stop: period holds its last value
				level_d = LEVEL_NONE;
				phase_d = '0;
				count_d = '0;
				spk_d   = 1'b0;
			end
		end else if (level_q != LEVEL_NONE) begin
			count_d = count_inc;
			if (count_inc >= phase_len) begin
				count_d = '0;
				phase_d = phase_next;
				if (level_q == LEVEL_HIGH) begin
					// chopped: tone loads only at the start of each half
					if (phase_next == '0) begin
						period_d = tone1;
					end else if (phase_next == PHASE_TONE2) begin
						period_d = tone2;
					end
					spk_d = !phase_next[0];
				end else begin
					period_d = (phase_next == '0) ? tone1 : tone2;
					spk_d    = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LEVEL_NONE;
			phase_q     <= '0;
			count_q     <= '0;
			period_q    <= RST_PERIOD_HOLD;
			spk_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				level_q  <= level_d;
				phase_q  <= phase_d;
				count_q  <= count_d;
				period_q <= period_d;
				spk_q    <= spk_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (tones.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q.pwm_period  <= period_d;
			out_word_q.speaker_on  <= spk_d;
			out_word_q.alarm_level <= level_d;
		end
	end

	assign tones.valid       = out_valid_q;
	assign tones.pwm_period  = out_word_q.pwm_period;
	assign tones.speaker_on  = out_word_q.speaker_on;
	assign tones.alarm_level = out_word_q.alarm_level;

endmodule
